[rtl/lst_pkg.sv]
// sequential list engine: shared types, command and status codes
// no dependencies; imported by every module of the block
package lst_pkg;

  localparam int DEF_LIST_DEPTH = 32;

  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int FPOS_W = 5;
  localparam int CNT_W  = 6;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [FPOS_W-1:0] found_position;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
  } res_t;

endpackage

[rtl/lst_ram.sv]
// sequential list engine: entry storage, one write and one read port
// registered read data; uses lst_pkg for the data width
module lst_ram #(
  parameter int DEPTH = lst_pkg::DEF_LIST_DEPTH,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [lst_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [lst_pkg::DATA_W-1:0] rdata
);
  import lst_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/lst_ctrl.sv]
// sequential list engine: command sequencer, entry count and shared compare
// walks the entry ram entry by entry, a shift step reading and writing together; uses lst_pkg
module lst_ctrl #(
  parameter int LIST_DEPTH = lst_pkg::DEF_LIST_DEPTH,
  parameter int IW         = 5,
  parameter int CW         = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        idle,
  input  logic [lst_pkg::CMD_W-1:0]   cmd,
  input  logic [lst_pkg::POS_W-1:0]   pos,
  input  logic [lst_pkg::DATA_W-1:0]  val,
  output logic                        ram_we,
  output logic [IW-1:0]               ram_waddr,
  output logic [lst_pkg::DATA_W-1:0]  ram_wdata,
  output logic                        ram_re,
  output logic [IW-1:0]               ram_raddr,
  input  logic [lst_pkg::DATA_W-1:0]  ram_rdata,
  output logic                        res_valid,
  output lst_pkg::res_t               res,
  input  logic                        res_ready
);
  import lst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_VAL  = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [IW-1:0]     found_r, found_nxt;

  logic [POS_W-1:0] pos_w;
  logic [POS_W-1:0] cnt_w;
  logic [CW-1:0]    k_inc;
  logic             match;

  assign pos_w = pos;
  assign cnt_w = POS_W'(cnt_r);
  assign k_inc = CW'(k_r) + CW'(1);
  assign match = (ram_rdata == val_r);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    ram_we     = 1'b0;
    ram_waddr  = k_r;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = k_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          found_nxt  = '0;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
          case (cmd)
            CMD_INSERT: begin
              if (cnt_r == CW'(LIST_DEPTH)) begin
                status_nxt = ST_FULL;
              end else if (pos_w > cnt_w) begin
                status_nxt = ST_BADPOS;
              end else if (pos_w == cnt_w) begin
                ram_we    = 1'b1;
                ram_waddr = IW'(pos);
                ram_wdata = val;
                cnt_nxt   = cnt_r + CW'(1);
              end else begin
                pos_nxt   = IW'(pos);
                val_nxt   = val;
                ram_re    = 1'b1;
                ram_raddr = IW'(cnt_r - CW'(1));
                k_nxt     = IW'(cnt_r);
                state_nxt = S_UP;
              end
            end
            CMD_DELETE: begin
              if (pos_w >= cnt_w) begin
                status_nxt = ST_BADPOS;
              end else if (pos_w == cnt_w - POS_W'(1)) begin
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IW'(pos) + IW'(1);
                k_nxt     = IW'(pos) + IW'(1);
                state_nxt = S_DN;
              end
            end
            CMD_FIND: begin
              val_nxt = val;
              if (cnt_r == '0) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                k_nxt     = '0;
                state_nxt = S_FIND;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = ram_rdata;
        if (k_r - IW'(1) == pos_r) begin
          state_nxt = S_VAL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = k_r - IW'(2);
          k_nxt     = k_r - IW'(1);
        end
      end
      S_VAL: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_FIN;
      end
      S_DN: begin
        ram_we    = 1'b1;
        ram_waddr = k_r - IW'(1);
        ram_wdata = ram_rdata;
        if (k_inc < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = k_r + IW'(1);
          k_nxt     = k_r + IW'(1);
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_FIND: begin
        if (match) begin
          found_nxt = k_r;
          state_nxt = S_FIN;
        end else if (k_inc < cnt_r) begin
          ram_re    = 1'b1;
          ram_raddr = k_r + IW'(1);
          k_nxt     = k_r + IW'(1);
        end else begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    k_r      <= k_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  assign idle                = (state_r == S_IDLE);
  assign res_valid           = (state_r == S_FIN);
  assign res.status          = status_r;
  assign res.found_position  = FPOS_W'(found_r);
  assign res.count           = CNT_W'(cnt_r);
  assign res.empty_res       = (cnt_r == '0);

endmodule

[rtl/sequential_list_engine.sv]
// sequential list engine top level: request handshake, sequencer, entry ram
// insert shifts the entries from the position upward and then writes the value; appending
// at the count writes at once; delete shifts the later entries down, while deleting the last
// entry only lowers the count; find compares from index 0 up to the first match or the count
// throughput: the next request is taken once the result moves to the output register, so a
// request waits for the one before it; the single ram port pair sets one shift or compare per cycle
// reset clears the entry count and control; entry contents are left as they are
module sequential_list_engine #(
  parameter int LIST_DEPTH = lst_pkg::DEF_LIST_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lst_pkg::CMD_W-1:0]    in_command,
  input  logic [lst_pkg::POS_W-1:0]    in_position,
  input  logic signed [lst_pkg::DATA_W-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lst_pkg::STAT_W-1:0]   out_status,
  output logic [lst_pkg::FPOS_W-1:0]   out_found_position,
  output logic [lst_pkg::CNT_W-1:0]    out_count,
  output logic                         out_empty_res
);
  import lst_pkg::*;

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic              idle;
  logic              start;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  assign in_ready  = idle;
  assign start     = in_valid && in_ready;
  assign res_ready = !out_valid_r || out_ready;

  lst_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .IW         (IW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .idle      (idle),
    .cmd       (in_command),
    .pos       (in_position),
    .val       (in_value),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  lst_ram #(
    .DEPTH (LIST_DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_res_r.status;
  assign out_found_position = out_res_r.found_position;
  assign out_count          = out_res_r.count;
  assign out_empty_res      = out_res_r.empty_res;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_W'(LIST_DEPTH)))
    else $error("count above list depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_found_position == '0))
    else $error("found position set on failed request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while sequencer busy");

endmodule
